// ----- hw/rtl/plq_pkg.sv -----
// Pitch lag quantizer package: widths, register codes, sequencer states,
// lag table and walk lengths. Used by plq_core and pitch_lag_quantizer_top.
package plq_pkg;

  localparam int LAG_W      = 10;
  localparam int WINDOW_LEN = 8;
  localparam int TABLE_LEN  = 64;
  localparam int WCNT_W     = $clog2(WINDOW_LEN);
  localparam int SUM_W      = LAG_W + $clog2(WINDOW_LEN);
  localparam int TIDX_W     = $clog2(TABLE_LEN);
  localparam int CHOICE_W   = 7;
  localparam int SCORE_W    = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CHOICE_W-1:0] NO_CHOICE  = '1;
  localparam logic [SCORE_W-1:0]  SCORE_INIT = SCORE_W'(1024);

  localparam logic [TIDX_W:0] WALK_S0 = (TIDX_W+1)'(TABLE_LEN / 2);
  localparam logic [TIDX_W:0] WALK_S1 = (TIDX_W+1)'(TABLE_LEN / 3);
  localparam logic [TIDX_W:0] WALK_S2 = (TIDX_W+1)'(TABLE_LEN / 4);
  localparam logic [TIDX_W:0] WALK_S3 = (TIDX_W+1)'(TABLE_LEN / 5);

  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAY_CREDIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPWARD_BIAS   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_KEY,
    S_SNAP,
    S_DONE
  } plq_state_t;

  typedef struct packed {
    logic [1:0] snap_strength;
    logic [3:0] stay_credit;
    logic [3:0] upward_bias;
  } plq_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } plq_stat_t;

  typedef struct packed {
    logic [LAG_W-1:0] central_lag;
    logic [LAG_W-1:0] snapped_lag;
    logic             voiced;
  } plq_res_t;

  function automatic logic [TIDX_W:0] walk_count(input logic [1:0] strength);
    logic [TIDX_W:0] n;
    case (strength)
      2'd0:    n = WALK_S0;
      2'd1:    n = WALK_S1;
      2'd2:    n = WALK_S2;
      default: n = WALK_S3;
    endcase
    return n;
  endfunction

  function automatic logic [LAG_W-1:0] snap_lut(input logic [TIDX_W-1:0] idx);
    logic [LAG_W-1:0] v;
    case (idx)
      6'd0:  v = 10'd14;   6'd1:  v = 10'd15;   6'd2:  v = 10'd16;   6'd3:  v = 10'd17;
      6'd4:  v = 10'd18;   6'd5:  v = 10'd19;   6'd6:  v = 10'd20;   6'd7:  v = 10'd22;
      6'd8:  v = 10'd23;   6'd9:  v = 10'd24;   6'd10: v = 10'd26;   6'd11: v = 10'd27;
      6'd12: v = 10'd29;   6'd13: v = 10'd31;   6'd14: v = 10'd32;   6'd15: v = 10'd34;
      6'd16: v = 10'd36;   6'd17: v = 10'd39;   6'd18: v = 10'd41;   6'd19: v = 10'd43;
      6'd20: v = 10'd46;   6'd21: v = 10'd49;   6'd22: v = 10'd51;   6'd23: v = 10'd54;
      6'd24: v = 10'd58;   6'd25: v = 10'd61;   6'd26: v = 10'd65;   6'd27: v = 10'd69;
      6'd28: v = 10'd73;   6'd29: v = 10'd77;   6'd30: v = 10'd82;   6'd31: v = 10'd86;
      6'd32: v = 10'd92;   6'd33: v = 10'd97;   6'd34: v = 10'd103;  6'd35: v = 10'd109;
      6'd36: v = 10'd115;  6'd37: v = 10'd122;  6'd38: v = 10'd130;  6'd39: v = 10'd137;
      6'd40: v = 10'd145;  6'd41: v = 10'd154;  6'd42: v = 10'd163;  6'd43: v = 10'd173;
      6'd44: v = 10'd183;  6'd45: v = 10'd194;  6'd46: v = 10'd206;  6'd47: v = 10'd218;
      6'd48: v = 10'd231;  6'd49: v = 10'd245;  6'd50: v = 10'd259;  6'd51: v = 10'd275;
      6'd52: v = 10'd291;  6'd53: v = 10'd308;  6'd54: v = 10'd327;  6'd55: v = 10'd346;
      6'd56: v = 10'd367;  6'd57: v = 10'd388;  6'd58: v = 10'd411;  6'd59: v = 10'd436;
      6'd60: v = 10'd462;  6'd61: v = 10'd489;  6'd62: v = 10'd518;  default: v = 10'd549;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/plq_core.sv -----
// Pitch lag quantizer core: lag window, central lag search and table walk
// on separate adder/compare paths under a small sequencer. Uses plq_pkg.
module plq_core import plq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LAG_W-1:0] raw_lag,
  input  plq_cfg_t         cfg,
  input  logic             ack,
  output plq_stat_t        stat,
  output plq_res_t         res
);

  plq_state_t state, state_next;

  logic [LAG_W-1:0]    win [WINDOW_LEN];
  logic [WCNT_W-1:0]   wcnt;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    best_key;
  logic [LAG_W-1:0]    central;
  logic [TIDX_W:0]     tcnt;
  logic [CHOICE_W-1:0] tidx;
  logic [SCORE_W-1:0]  best_score;
  logic [TIDX_W-1:0]   pick_idx;
  logic [CHOICE_W-1:0] last_choice;

  // central search
  logic [SUM_W-1:0]        scaled;
  logic signed [SUM_W:0]   key_diff;
  logic [SUM_W-1:0]        key_abs;
  logic                    key_take;
  logic [LAG_W-1:0]        cand;
  logic                    win_last;

  assign scaled   = SUM_W'(win[0] * WINDOW_LEN);
  assign key_diff = $signed({1'b0, sum}) - $signed({1'b0, scaled});
  assign key_abs  = key_diff[SUM_W] ? SUM_W'(-key_diff) : key_diff[SUM_W-1:0];
  assign key_take = (wcnt == '0) || (key_abs < best_key);
  assign cand     = key_take ? win[0] : central;
  assign win_last = (wcnt == WCNT_W'(WINDOW_LEN - 1));

  // table walk
  logic [LAG_W-1:0]          tab;
  logic signed [SCORE_W-1:0] err;
  logic signed [SCORE_W-1:0] score;
  logic [SCORE_W-1:0]        abs_err;
  logic [2:0]                stride;
  logic                      snap_take;
  logic                      snap_last;

  assign tab     = snap_lut(tidx[TIDX_W-1:0]);
  assign err     = $signed({2'b0, central}) - $signed({2'b0, tab});
  assign abs_err = err[SCORE_W-1] ? SCORE_W'(-err) : SCORE_W'(err);
  assign score   = $signed(abs_err)
                 - $signed((last_choice == tidx) ? {8'd0, cfg.stay_credit} : 12'd0)
                 - $signed((err > 0) ? {8'd0, cfg.upward_bias} : 12'd0);
  assign snap_take = score < $signed(best_score);
  assign stride    = {1'b0, cfg.snap_strength} + 3'd2;
  assign snap_last = (tcnt == walk_count(cfg.snap_strength) - 1'b1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_SUM;
      S_SUM:  if (win_last) state_next = S_KEY;
      S_KEY:  if (win_last) state_next = (cand != '0) ? S_SNAP : S_DONE;
      S_SNAP: if (snap_last) state_next = S_DONE;
      S_DONE: if (ack) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    stat.busy       = (state != S_IDLE);
    stat.done       = (state == S_DONE);
    res.central_lag = central;
    res.voiced      = (central != '0);
    res.snapped_lag = res.voiced ? snap_lut(pick_idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_choice <= NO_CHOICE;
      for (int i = 0; i < WINDOW_LEN; i++) win[i] <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            win[WINDOW_LEN-1] <= raw_lag;
            wcnt       <= '0;
            sum        <= '0;
            tcnt       <= '0;
            tidx       <= '0;
            best_score <= SCORE_INIT;
            pick_idx   <= '0;
          end
        end
        S_SUM, S_KEY: begin
          // rotate so each entry passes slot 0 once
          for (int i = 0; i < WINDOW_LEN - 1; i++) win[i] <= win[i+1];
          win[WINDOW_LEN-1] <= win[0];
          wcnt <= win_last ? '0 : wcnt + 1'b1;
          if (state == S_SUM) begin
            sum <= sum + SUM_W'(win[0]);
          end else begin
            if (key_take) begin
              best_key <= key_abs;
              central  <= win[0];
            end
            if (win_last && cand == '0) last_choice <= NO_CHOICE;
          end
        end
        S_SNAP: begin
          if (snap_take) begin
            best_score <= score;
            pick_idx   <= tidx[TIDX_W-1:0];
          end
          tcnt <= tcnt + 1'b1;
          tidx <= tidx + CHOICE_W'(stride);
          if (snap_last) last_choice <= snap_take ? tidx : {1'b0, pick_idx};
        end
        S_DONE: begin
          if (ack) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) win[i] <= win[i+1];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pitch_lag_quantizer_top.sv -----
// Pitch lag quantizer top level: config registers, handshakes, output word
// register and checks. Uses plq_pkg and plq_core.
//
// One raw lag word in, one result word out. Each word goes through a window
// sum, then a nearest-to-mean search, then, when the central lag is nonzero,
// a walk over every (2+snap_strength)-th table entry. in_ready is low while
// a word is in work; a finished result waits in the output register, and the
// core holds its next result until that register frees. Config writes are
// always taken.
module pitch_lag_quantizer_top import plq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LAG_W-1:0]     raw_lag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LAG_W-1:0]     central_lag,
  output logic [LAG_W-1:0]     snapped_lag,
  output logic                 voiced,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  plq_cfg_t  cfg;
  plq_stat_t stat;
  plq_res_t  res;
  logic      start;
  logic      load;

  assign cfg_ready = 1'b1;
  assign in_ready  = !stat.busy;
  assign start     = in_valid && in_ready;
  assign load      = stat.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.snap_strength <= 2'd0;
      cfg.stay_credit   <= 4'd1;
      cfg.upward_bias   <= 4'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SNAP_STRENGTH: cfg.snap_strength <= cfg_data[1:0];
        CFG_STAY_CREDIT:   cfg.stay_credit   <= cfg_data[3:0];
        CFG_UPWARD_BIAS:   cfg.upward_bias   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  plq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .raw_lag (raw_lag),
    .cfg     (cfg),
    .ack     (load),
    .stat    (stat),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      central_lag <= res.central_lag;
      snapped_lag <= res.snapped_lag;
      voiced      <= res.voiced;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("core not busy after input word");

  a_done_implies_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> stat.busy && !in_ready)
    else $error("result pending while input open");

  a_voiced_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (voiced == (central_lag != '0)))
    else $error("voiced flag disagrees with central lag");

  a_snapped_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (voiced ? (snapped_lag >= 10'd14 && snapped_lag <= 10'd549)
                          : (snapped_lag == '0)))
    else $error("snapped lag outside table");

endmodule

// ----- tb/plq_checker.sv -----
`timescale 1ns / 100ps
// Pitch lag quantizer checker: watches the lag, result and register channels,
// predicts each result word and compares it field by field. Uses plq_pkg.
module plq_checker
  import plq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [LAG_W-1:0]     raw_lag,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [LAG_W-1:0]     central_lag,
  input  logic [LAG_W-1:0]     snapped_lag,
  input  logic                 voiced,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   n_results,
  output int                   n_voiced
);

  localparam logic [LAG_W-1:0] GRID_LAGS [TABLE_LEN] = '{
    10'd14,  10'd15,  10'd16,  10'd17,  10'd18,  10'd19,  10'd20,  10'd22,
    10'd23,  10'd24,  10'd26,  10'd27,  10'd29,  10'd31,  10'd32,  10'd34,
    10'd36,  10'd39,  10'd41,  10'd43,  10'd46,  10'd49,  10'd51,  10'd54,
    10'd58,  10'd61,  10'd65,  10'd69,  10'd73,  10'd77,  10'd82,  10'd86,
    10'd92,  10'd97,  10'd103, 10'd109, 10'd115, 10'd122, 10'd130, 10'd137,
    10'd145, 10'd154, 10'd163, 10'd173, 10'd183, 10'd194, 10'd206, 10'd218,
    10'd231, 10'd245, 10'd259, 10'd275, 10'd291, 10'd308, 10'd327, 10'd346,
    10'd367, 10'd388, 10'd411, 10'd436, 10'd462, 10'd489, 10'd518, 10'd549
  };

  logic [LAG_W-1:0]    hist [WINDOW_LEN];
  logic [CHOICE_W-1:0] last_pick;
  logic [1:0]          strength;
  logic [3:0]          stay;
  logic [3:0]          bias;
  plq_res_t            lag_results [$];
  plq_res_t            want;
  plq_res_t            got;
  int                  err_count = 0;
  int                  seen = 0;
  int                  seen_voiced = 0;
  int                  j;

  function automatic plq_res_t quantize_lag(input logic [LAG_W-1:0] lag);
    plq_res_t r;
    int       i;
    int       sum;
    int       key;
    int       best_key;
    int       stride;
    int       err;
    int       score;
    int       best_score;
    int       pick;
    hist[WINDOW_LEN-1] = lag;
    sum = 0;
    for (i = 0; i < WINDOW_LEN; i++) sum += int'(hist[i]);
    r = '0;
    best_key = 0;
    for (i = 0; i < WINDOW_LEN; i++) begin
      key = sum - WINDOW_LEN * int'(hist[i]);
      if (key < 0) key = -key;
      if (i == 0 || key < best_key) begin
        best_key = key;
        r.central_lag = hist[i];
      end
    end
    if (r.central_lag != '0) begin
      stride     = 2 + int'(strength);
      best_score = 1024;
      pick       = 0;
      for (i = 0; i < TABLE_LEN / stride; i++) begin
        err   = int'(r.central_lag) - int'(GRID_LAGS[i * stride]);
        score = (err < 0) ? -err : err;
        if (int'(last_pick) == i * stride) score -= int'(stay);
        if (err > 0) score -= int'(bias);
        if (score < best_score) begin
          best_score = score;
          pick       = i * stride;
        end
      end
      last_pick     = CHOICE_W'(pick);
      r.snapped_lag = GRID_LAGS[pick];
      r.voiced      = 1'b1;
    end else begin
      last_pick = NO_CHOICE;
    end
    for (i = 0; i < WINDOW_LEN - 1; i++) hist[i] = hist[i+1];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (j = 0; j < WINDOW_LEN; j++) hist[j] = '0;
      last_pick = NO_CHOICE;
      strength  = 2'd0;
      stay      = 4'd1;
      bias      = 4'd0;
      lag_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SNAP_STRENGTH: strength = cfg_data[1:0];
          CFG_STAY_CREDIT:   stay     = cfg_data[3:0];
          CFG_UPWARD_BIAS:   bias     = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) lag_results.push_back(quantize_lag(raw_lag));
      if (out_valid && out_ready) begin
        got.central_lag = central_lag;
        got.snapped_lag = snapped_lag;
        got.voiced      = voiced;
        seen++;
        if (got.voiced === 1'b1) seen_voiced++;
        if (lag_results.size() == 0) begin
          err_count++;
          $display("%0t plq_checker: unexpected word: central %0d snapped %0d voiced %0d",
                   $time, got.central_lag, got.snapped_lag, got.voiced);
        end else begin
          want = lag_results.pop_front();
          if (got.central_lag !== want.central_lag || got.snapped_lag !== want.snapped_lag ||
              got.voiced !== want.voiced) begin
            err_count++;
            $display("%0t plq_checker: word %0d mismatch", $time, seen);
            $display("  expected central %0d snapped %0d voiced %0d",
                     want.central_lag, want.snapped_lag, want.voiced);
            $display("  actual   central %0d snapped %0d voiced %0d",
                     got.central_lag, got.snapped_lag, got.voiced);
          end
        end
      end
    end
    errors    <= err_count;
    pending   <= lag_results.size();
    n_results <= seen;
    n_voiced  <= seen_voiced;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Pitch lag quantizer testbench top: clock, reset, lag and register stimulus,
// result receiver and verdict. Uses plq_pkg, plq_checker, pitch_lag_quantizer_top.
module tb_top;
  import plq_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_LAGS    = 255;
  localparam int CORNER_COUNT  = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [LAG_W-1:0] CORNER_LAGS [CORNER_COUNT] = '{
    10'd0,    10'd0,    10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd1023, 10'd1,    10'd1,    10'd1,    10'd1,    10'd1,    10'd1,
    10'd0,    10'd0,    10'd0,    10'd0,    10'd0,    10'd0,    10'd512,
    10'd513,  10'd300,  10'd301,  10'd14
  };

  typedef enum logic [1:0] {
    RUN_VOICED,
    RUN_SILENT,
    RUN_NOISE
  } run_kind_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [LAG_W-1:0]     raw_lag   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SNAP_STRENGTH;
  logic [7:0]           cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  logic [LAG_W-1:0]     central_lag;
  logic [LAG_W-1:0]     snapped_lag;
  logic                 voiced;

  int        errors;
  int        pending;
  int        n_results;
  int        n_voiced;
  int        cycle_count   = 0;
  int        lags_sent     = 0;
  int        settings_used = 0;
  bit        tx_calm       = 1'b0;
  bit        rx_calm       = 1'b0;
  bit        hold_req      = 1'b0;
  run_kind_t run_kind      = RUN_VOICED;
  int        run_left      = 0;
  int        track         = 100;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pitch_lag_quantizer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .raw_lag     (raw_lag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .central_lag (central_lag),
    .snapped_lag (snapped_lag),
    .voiced      (voiced),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  plq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .raw_lag     (raw_lag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .central_lag (central_lag),
    .snapped_lag (snapped_lag),
    .voiced      (voiced),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending),
    .n_results   (n_results),
    .n_voiced    (n_voiced)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("tb_top: FAIL");
    $finish;
  end

  // result receiver: random stall per word, long hold-off on request
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 18);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_lag(input logic [LAG_W-1:0] lag);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_lag  <= lag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lags_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all registers back to back, the spare index included
  task automatic set_regs(input logic [1:0] strength, input logic [3:0] stay,
                          input logic [3:0] bias);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [7:0]           data [4];
    int                   k;
    idx[0]  = CFG_SPARE;
    idx[1]  = CFG_SNAP_STRENGTH;
    idx[2]  = CFG_STAY_CREDIT;
    idx[3]  = CFG_UPWARD_BIAS;
    data[0] = 8'($urandom_range(0, 255));
    data[1] = {6'($urandom_range(0, 63)), strength};
    data[2] = {4'($urandom_range(0, 15)), stay};
    data[3] = {4'($urandom_range(0, 15)), bias};
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= data[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // mostly drifting voiced runs, with silent stretches and raw noise
  task automatic run_phase(input logic [1:0] strength, input logic [3:0] stay,
                           input logic [3:0] bias, input bit pressure);
    int k;
    int r;
    wait_idle();
    set_regs(strength, stay, bias);
    tx_calm  = ($urandom_range(0, 3) == 0);
    rx_calm  = ($urandom_range(0, 3) == 0);
    hold_req = pressure;
    for (k = 0; k < PHASE_LAGS; k++) begin
      if (k % 50 == 49) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          run_kind = RUN_VOICED;
          run_left = $urandom_range(4, 30);
          track    = $urandom_range(14, 700);
        end else if (r < 85) begin
          run_kind = RUN_SILENT;
          run_left = $urandom_range(3, 12);
        end else begin
          run_kind = RUN_NOISE;
          run_left = $urandom_range(1, 8);
        end
      end
      run_left--;
      case (run_kind)
        RUN_VOICED: begin
          if ($urandom_range(0, 15) == 0) track = $urandom_range(14, 700);
          else track = track + int'($urandom_range(0, 8)) - 4;
          if (track < 1) track = 1;
          if (track > 1023) track = 1023;
          send_lag(LAG_W'(track));
        end
        RUN_SILENT: send_lag('0);
        default:    send_lag(LAG_W'($urandom_range(0, 1023)));
      endcase
    end
  endtask

  initial begin
    int k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < CORNER_COUNT; k++) send_lag(CORNER_LAGS[k]);
    run_phase(2'd0, 4'd0, 4'd0, 1'b0);
    run_phase(2'd2, 4'd15, 4'd15, 1'b0);
    run_phase(2'd3, 4'd15, 4'd0, 1'b1);
    run_phase(2'd1, 4'd7, 4'd15, 1'b0);
    run_phase(2'd0, 4'd15, 4'd8, 1'b1);
    run_phase(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 1'b0);
    wait_idle();
    $display("tb_top: %0d lags over %0d register settings, %0d results checked (%0d voiced)",
             lags_sent, settings_used, n_results, n_voiced);
    $display("tb_top: strides 2 to 5, receiver hold-offs of %0d cycles, %0d cycles in all",
             HOLD_CYCLES, cycle_count);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/plq_pkg.sv
hw/rtl/plq_core.sv
hw/rtl/pitch_lag_quantizer_top.sv
tb/plq_checker.sv
tb/tb_top.sv
